FILE: rtl/staged_command_queue_unit_assert.svh
// Assertion macros for the staged command queue unit.
// Included by the top level; no other dependencies.
`ifndef STAGED_COMMAND_QUEUE_UNIT_ASSERT_SVH
`define STAGED_COMMAND_QUEUE_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define SCQ_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define SCQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SCQ_ASSERT(lbl, clk, rstn, prop, msg)
`define SCQ_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

FILE: rtl/scq_pkg.sv
// Shared types and constants for the staged command queue unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package scq_pkg;

  localparam int unsigned STAGE_BYTES_DEF = 64;
  localparam int unsigned FIFO_DEPTH_DEF  = 8;

  // step codes
  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_TICK  = 2'd1;
  localparam logic [1:0] MODE_RESP  = 2'd2;

  // register indexes
  localparam logic [1:0] CFG_BASE_ADDR = 2'd0;
  localparam logic [1:0] CFG_SYNC_WR   = 2'd1;
  localparam logic [1:0] CFG_LATENCY   = 2'd2;

  localparam logic [15:0] LATENCY_RST    = 16'd1;
  localparam logic [3:0]  MAX_WR_BYTES   = 4'd8;
  localparam logic [3:0]  OPCODE_SYNC    = 4'd1;
  localparam int unsigned WORD_BYTES     = 4;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] bus_address;
    logic [63:0] write_data;
    logic [3:0]  write_size;
  } scq_in_t;

  typedef struct packed {
    logic        accepted;
    logic        range_error;
    logic        sync_valid;
    logic [31:0] sync_word;
    logic [3:0]  queue_count;
    logic        busy_res;
    logic [31:0] completed_count;
  } scq_out_t;

  typedef struct packed {
    logic empty;
    logic full;
  } scq_q_stat_t;

  typedef struct packed {
    logic        sync_valid;
    logic [31:0] sync_word;
    logic        busy;
    logic [31:0] done_count;
  } scq_exec_res_t;

endpackage
`default_nettype wire

FILE: rtl/scq_queue.sv
// Command queue: circular buffer of command words with head and fill count.
// Depends on scq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module scq_queue import scq_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF,
  localparam int unsigned HW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1,
  localparam int unsigned FW = $clog2(FIFO_DEPTH + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire logic [31:0]   push_word,
  input  wire logic          pop,
  output logic [31:0]        head_word,
  output scq_q_stat_t        stat,
  output logic [FW-1:0]      fill_nxt
);

  localparam int unsigned SW = FW + 1;

  logic [31:0]   words_r [FIFO_DEPTH];
  logic [31:0]   head_word_r;
  logic [HW-1:0] head_r, head_nxt;
  logic [FW-1:0] fill_r;
  logic [SW-1:0] tail_sum;
  logic [SW-1:0] tail_wrap;

  always_comb begin
    tail_sum  = SW'(head_r) + SW'(fill_r);
    tail_wrap = (tail_sum >= SW'(FIFO_DEPTH)) ? tail_sum - SW'(FIFO_DEPTH) : tail_sum;
  end

  assign stat.empty = (fill_r == '0);
  assign stat.full  = (fill_r == FW'(FIFO_DEPTH));
  assign head_word  = head_word_r;

  always_comb begin
    head_nxt = head_r;
    fill_nxt = fill_r;
    if (push) begin
      fill_nxt = fill_r + FW'(1);
    end else if (pop) begin
      fill_nxt = fill_r - FW'(1);
      head_nxt = (head_r == HW'(FIFO_DEPTH - 1)) ? '0 : head_r + HW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      fill_r <= '0;
    end else begin
      head_r <= head_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      words_r[tail_wrap[HW-1:0]] <= push_word;
    end
  end

  // head entry is read ahead; a push into an empty queue lands on the head
  always_ff @(posedge clk) begin
    if (push && (tail_wrap[HW-1:0] == head_nxt)) begin
      head_word_r <= push_word;
    end else begin
      head_word_r <= words_r[head_nxt];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/scq_exec.sv
// Execution engine: issues queued commands on ticks, counts latency,
// completes them and raises sync words. Depends on scq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module scq_exec import scq_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          tick,
  input  wire logic          resp,
  input  wire logic [15:0]   latency,
  input  wire scq_q_stat_t   q_stat,
  input  wire logic [31:0]   head_word,
  output logic               pop,
  output scq_exec_res_t      res
);

  logic        exec_r, exec_nxt;
  logic [15:0] ticks_r, ticks_nxt, ticks_dec;
  logic [31:0] act_r, act_nxt;
  logic        sync_pend_r, sync_pend_nxt;
  logic [31:0] done_r, done_nxt;
  logic        sync_fire;

  always_comb begin
    exec_nxt      = exec_r;
    ticks_nxt     = ticks_r;
    act_nxt       = act_r;
    sync_pend_nxt = sync_pend_r;
    done_nxt      = done_r;
    pop           = 1'b0;
    sync_fire     = 1'b0;
    ticks_dec     = ticks_r - 16'((ticks_r != '0) ? 1 : 0);
    if (tick) begin
      if (exec_r) begin
        ticks_nxt = ticks_dec;
        if (ticks_dec == '0) begin
          exec_nxt = 1'b0;
          done_nxt = done_r + 32'd1;
          if (act_r[19:16] == OPCODE_SYNC) begin
            sync_fire     = 1'b1;
            sync_pend_nxt = 1'b1;
          end
        end
      end else if (!q_stat.empty && !sync_pend_r) begin
        pop       = 1'b1;
        act_nxt   = head_word;
        exec_nxt  = 1'b1;
        ticks_nxt = (latency == '0) ? 16'd1 : latency;
      end
    end else if (resp) begin
      sync_pend_nxt = 1'b0;
    end
  end

  // type, id, opcode and index are the low 28 bits of the command word
  assign res.sync_valid = sync_fire;
  assign res.sync_word  = sync_fire ? {4'h0, act_r[27:0]} : '0;
  assign res.busy       = exec_nxt;
  assign res.done_count = done_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exec_r      <= 1'b0;
      ticks_r     <= '0;
      act_r       <= '0;
      sync_pend_r <= 1'b0;
      done_r      <= '0;
    end else begin
      exec_r      <= exec_nxt;
      ticks_r     <= ticks_nxt;
      act_r       <= act_nxt;
      sync_pend_r <= sync_pend_nxt;
      done_r      <= done_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/staged_command_queue_unit.sv
// Staged command queue unit: input register, write decode and staging word,
// command queue, execution engine and result register. Depends on scq_pkg,
// scq_queue, scq_exec and staged_command_queue_unit_assert.svh.
//
// One step (MMIO write, tick or sync response) is taken per cycle whenever
// busy is low; busy is high during reset and for the first cycle after it.
// Each step yields exactly one result, shown on out_data with out_valid for
// a single cycle; it passes through the input register, then through the
// decode, queue and engine logic into the result register. The receiver
// cannot stall, so results must be taken as they appear. Configuration
// writes are always ready and must only be issued while no step is in flight.
// Only the first four staging bytes form the command word, so only they are
// held; writes to the rest of the staging area are taken and dropped.
`timescale 1ns / 1ps
`default_nettype none
`include "staged_command_queue_unit_assert.svh"
module staged_command_queue_unit import scq_pkg::*; #(
  parameter int unsigned STAGE_BYTES = STAGE_BYTES_DEF,
  parameter int unsigned FIFO_DEPTH  = FIFO_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire scq_in_t     in_data,
  output logic             out_valid,
  output scq_out_t         out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int unsigned SPAN = 2 * STAGE_BYTES;
  localparam int unsigned FW   = $clog2(FIFO_DEPTH + 1);

  logic        busy_r;
  logic [31:0] base_r;
  logic        sync_wr_r;
  logic [15:0] lat_r;

  logic        in_vld_r;
  scq_in_t     in_r;
  logic        out_vld_r;
  scq_out_t    out_r, out_nxt;

  logic [31:0] stage_r, stage_nxt;
  logic [31:0] off;
  logic        is_write, bad, in_stage, wr_store, launch, push;
  logic [1:0]  byte_k;

  scq_q_stat_t   q_stat;
  logic [31:0]   head_word;
  logic [FW-1:0] fill_nxt;
  logic          pop;
  scq_exec_res_t ex_res;

  assign busy      = busy_r;
  assign cfg_ready = 1'b1;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b1;
      base_r    <= '0;
      sync_wr_r <= 1'b0;
      lat_r     <= LATENCY_RST;
    end else begin
      busy_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_BASE_ADDR: base_r    <= cfg_data;
          CFG_SYNC_WR:   sync_wr_r <= cfg_data[0];
          CFG_LATENCY:   lat_r     <= cfg_data[15:0];
          default:       ;
        endcase
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= start && !busy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      in_r <= in_data;
    end
  end

  // write decode
  always_comb begin
    is_write = in_vld_r && (in_r.mode == MODE_WRITE);
    off      = in_r.bus_address - base_r;
    bad      = (in_r.write_size == '0) || (in_r.write_size > MAX_WR_BYTES) ||
               (({1'b0, off} + 33'(in_r.write_size)) > 33'(SPAN));
    in_stage = (off < 32'(STAGE_BYTES));
    wr_store = is_write && !bad && in_stage && (off < 32'(WORD_BYTES));
    launch   = is_write && !bad &&
               (!in_stage || (sync_wr_r && (off == '0)));
    push     = launch && !q_stat.full;
  end

  always_comb begin
    stage_nxt = stage_r;
    byte_k    = '0;
    for (int b = 0; b < WORD_BYTES; b++) begin
      byte_k = 2'(b) - off[1:0];
      if (wr_store && (2'(b) >= off[1:0]) && ({2'b00, byte_k} < in_r.write_size)) begin
        stage_nxt[8*b +: 8] = in_r.write_data[{byte_k, 3'b000} +: 8];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= '0;
    end else begin
      stage_r <= stage_nxt;
    end
  end

  scq_queue #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_word (stage_nxt),
    .pop       (pop),
    .head_word (head_word),
    .stat      (q_stat),
    .fill_nxt  (fill_nxt)
  );

  scq_exec u_exec (
    .clk       (clk),
    .rst_n     (rst_n),
    .tick      (in_vld_r && (in_r.mode == MODE_TICK)),
    .resp      (in_vld_r && (in_r.mode == MODE_RESP)),
    .latency   (lat_r),
    .q_stat    (q_stat),
    .head_word (head_word),
    .pop       (pop),
    .res       (ex_res)
  );

  // result register
  always_comb begin
    out_nxt.accepted        = is_write && !bad && (!launch || !q_stat.full);
    out_nxt.range_error     = is_write && bad;
    out_nxt.sync_valid      = ex_res.sync_valid;
    out_nxt.sync_word       = ex_res.sync_word;
    out_nxt.queue_count     = 4'(fill_nxt);
    out_nxt.busy_res        = ex_res.busy;
    out_nxt.completed_count = ex_res.done_count;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld_r) begin
      out_r <= out_nxt;
    end
  end

  `SCQ_ASSERT(a_err_not_acc, clk, rst_n, out_valid |-> !(out_data.range_error && out_data.accepted), "range error reported as accepted")
  `SCQ_ASSERT(a_sync_idle, clk, rst_n, (out_valid && out_data.sync_valid) |-> !out_data.busy_res, "sync word while still executing")
  `SCQ_ASSERT(a_done_step, clk, rst_n, (out_valid && $past(out_valid)) |-> ((out_data.completed_count - $past(out_data.completed_count)) <= 32'd1), "completion count jumped")
  `SCQ_ASSERT_ALWAYS(a_rst_busy, clk, $past(!rst_n) |-> busy, "accepting right after reset")

endmodule
`default_nettype wire
